FILE: rtl/cicd_pkg.sv
// ----------------------------------------------------------------------------
// cicd_pkg
// Shared constants, request codes and controller/datapath interface structs
// for the cloud-in-cell density deposit block.
// ----------------------------------------------------------------------------
package cicd_pkg;

    localparam int GRID_X_DEF        = 64;
    localparam int GRID_Y_DEF        = 64;
    localparam int MAX_PARTICLES_DEF = 4096;

    localparam int REQ_W  = 2;
    localparam int POS_W  = 24;
    localparam int DENS_W = 29;
    localparam int FRAC_W = 16;

    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DENS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BIN  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic acc_load;   // load transaction accepted
        logic lay;        // lay out grid from bounding box
        logic clr_wr;     // clear one density node
        logic p_rd;       // read stored particle
        logic p_chk;      // start binning of particle read data
        logic div_step;   // one quotient bit, both axes
        logic bin_wr;     // write bin/frac, latch node base
        logic w_rd;       // read density node, form weight
        logic w_wr;       // accumulate into density node
        logic next_part;  // advance particle pointer
        logic q_dens;     // density query read
        logic q_bin;      // binning query read
        logic out_load;   // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic empty;
        logic lost;
        logic div_done;
        logic node_last;
        logic last_part;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/cicd_ctrl.sv
// ----------------------------------------------------------------------------
// cicd_ctrl
// Sequencer: request decode, clear sweep, per-particle binning and the four
// node updates of each deposit.
// ----------------------------------------------------------------------------
module cicd_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cicd_pkg::REQ_W-1:0] req_type,
    input  logic                       last_particle,
    input  cicd_pkg::sts_t             sts,
    output cicd_pkg::cmd_t             cmd
);
    import cicd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LAY   = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PCHK  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_BINW  = 4'd6;
    localparam logic [3:0] S_WRD   = 4'd7;
    localparam logic [3:0] S_WWR   = 4'd8;
    localparam logic [3:0] S_QWAIT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_LOAD:
                        begin
                            cmd.acc_load = 1'b1;
                            if (last_particle)
                                state_next = S_LAY;
                        end
                        REQ_DENS:
                        begin
                            cmd.q_dens = 1'b1;
                            state_next = S_QWAIT;
                        end
                        REQ_BIN:
                        begin
                            cmd.q_bin  = 1'b1;
                            state_next = S_QWAIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_LAY:
            begin
                cmd.lay    = 1'b1;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done)
                    state_next = sts.empty ? S_IDLE : S_PRD;
            end
            S_PRD:
            begin
                cmd.p_rd   = 1'b1;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                cmd.p_chk = 1'b1;
                if (sts.lost)
                begin
                    cmd.next_part = 1'b1;
                    state_next    = sts.last_part ? S_IDLE : S_PRD;
                end
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_BINW;
            end
            S_BINW:
            begin
                cmd.bin_wr = 1'b1;
                state_next = S_WRD;
            end
            S_WRD:
            begin
                cmd.w_rd   = 1'b1;
                state_next = S_WWR;
            end
            S_WWR:
            begin
                cmd.w_wr = 1'b1;
                if (sts.node_last)
                begin
                    cmd.next_part = 1'b1;
                    state_next    = sts.last_part ? S_IDLE : S_PRD;
                end
                else
                    state_next = S_WRD;
            end
            S_QWAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/cicd_dpath.sv
// ----------------------------------------------------------------------------
// cicd_dpath
// Particle, binning and density memories, bounding box, grid layout,
// restoring divider for both axes and the saturating weight accumulator.
// ----------------------------------------------------------------------------
module cicd_dpath #(
    parameter int GRID_X        = cicd_pkg::GRID_X_DEF,
    parameter int GRID_Y        = cicd_pkg::GRID_Y_DEF,
    parameter int MAX_PARTICLES = cicd_pkg::MAX_PARTICLES_DEF,
    parameter int CXW           = $clog2(GRID_X + 1),
    parameter int CYW           = $clog2(GRID_Y + 1),
    parameter int PW            = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cicd_pkg::cmd_t                      cmd,
    output cicd_pkg::sts_t                      sts,
    input  logic signed [cicd_pkg::POS_W-1:0]   pos_x,
    input  logic signed [cicd_pkg::POS_W-1:0]   pos_y,
    input  logic                                is_lost,
    input  logic [CXW-1:0]                      cell_x,
    input  logic [CYW-1:0]                      cell_y,
    input  logic [PW-1:0]                       particle_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cicd_pkg::DENS_W-1:0]         density,
    output logic [CXW-1:0]                      bin_x,
    output logic [CYW-1:0]                      bin_y,
    output logic [cicd_pkg::FRAC_W-1:0]         frac_x,
    output logic [cicd_pkg::FRAC_W-1:0]         frac_y
);
    import cicd_pkg::*;

    localparam int CW    = $clog2(MAX_PARTICLES + 1);
    localparam int GBX   = $clog2(GRID_X);
    localparam int GBY   = $clog2(GRID_Y);
    localparam int GBM   = (GBX > GBY) ? GBX : GBY;
    localparam int QW    = GBM + FRAC_W;
    localparam int DCW   = $clog2(QW);
    localparam int DSW   = POS_W + 2;          // 4*extent fits here
    localparam int NWD   = DSW + GBM + 1;
    localparam int NODES = (GRID_X + 1) * (GRID_Y + 1);
    localparam int NW    = $clog2(NODES);
    localparam int BEW   = CXW + CYW + 2 * FRAC_W;
    localparam int PEW   = 2 * POS_W + 1;
    localparam int WW    = FRAC_W + 1;
    localparam int SW    = DENS_W + 1;
    localparam logic [WW-1:0]     ONE_Q16  = WW'(1) << FRAC_W;
    localparam logic [DENS_W-1:0] DENS_MAX = '1;
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // ---------------- memories ----------------
    logic [PEW-1:0]    pmem [MAX_PARTICLES];
    logic [BEW-1:0]    bmem [MAX_PARTICLES];
    logic [DENS_W-1:0] dmem [NODES];
    logic [PEW-1:0]    prd_reg;
    logic [BEW-1:0]    brd_reg;
    logic [DENS_W-1:0] drd_reg;

    // ---------------- control state ----------------
    logic [CW-1:0]  count_reg, count_next;
    logic signed [POS_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [POS_W-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
    logic           closed_reg;
    logic           grid_ok_reg;  // density memory cleared by a deposition
    logic [CW-1:0]  idx_reg;
    logic [1:0]     k_reg;
    logic [NW-1:0]  clr_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           out_valid_reg;

    // ---------------- datapath payload ----------------
    logic signed [POS_W+2:0] org_x_reg, org_y_reg;
    logic [DSW-1:0]   den_x_reg, den_y_reg;
    logic [DSW-1:0]   rem_x_reg, rem_y_reg;
    logic [QW-1:0]    dlo_x_reg, dlo_y_reg;
    logic [QW-1:0]    q_x_reg, q_y_reg;
    logic [NW-1:0]    base_reg;
    logic [NW-1:0]    wa_reg;
    logic [2*WW-1:0]  prod_reg;
    logic             off_reg;
    logic             qsel_reg;   // 1: density query

    // ---------------- load / box ----------------
    logic room;
    logic [PW-1:0] la;
    logic signed [POS_W-1:0] bmin_x, bmax_x, bmin_y, bmax_y;

    assign room = closed_reg || (count_reg < CW'(MAX_PARTICLES));
    assign la   = closed_reg ? '0 : count_reg[PW-1:0];

    always_comb
    begin
        bmin_x     = closed_reg ? POS_MAX : min_x_reg;
        bmax_x     = closed_reg ? POS_MIN : max_x_reg;
        bmin_y     = closed_reg ? POS_MAX : min_y_reg;
        bmax_y     = closed_reg ? POS_MIN : max_y_reg;
        min_x_next = bmin_x;
        max_x_next = bmax_x;
        min_y_next = bmin_y;
        max_y_next = bmax_y;
        if (room && !is_lost)
        begin
            if (pos_x < bmin_x) min_x_next = pos_x;
            if (pos_x > bmax_x) max_x_next = pos_x;
            if (pos_y < bmin_y) min_y_next = pos_y;
            if (pos_y > bmax_y) max_y_next = pos_y;
        end
        if (closed_reg)
            count_next = CW'(1);
        else if (room)
            count_next = count_reg + CW'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_load && room)
            pmem[la] <= {pos_x, pos_y, is_lost};
        if (cmd.p_rd)
            prd_reg <= pmem[idx_reg[PW-1:0]];
    end

    // ---------------- grid layout ----------------
    logic signed [POS_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [POS_W:0] ex_d, ey_d;
    logic [POS_W-1:0] ex, ey;

    always_comb
    begin
        lo_x = (min_x_reg <= max_x_reg) ? min_x_reg : '0;
        hi_x = (min_x_reg <= max_x_reg) ? max_x_reg : '0;
        lo_y = (min_y_reg <= max_y_reg) ? min_y_reg : '0;
        hi_y = (min_y_reg <= max_y_reg) ? max_y_reg : '0;
        ex_d = {hi_x[POS_W-1], hi_x} - {lo_x[POS_W-1], lo_x};
        ey_d = {hi_y[POS_W-1], hi_y} - {lo_y[POS_W-1], lo_y};
        ex   = (ex_d[POS_W-1:0] == '0) ? POS_W'(1) : ex_d[POS_W-1:0];
        ey   = (ey_d[POS_W-1:0] == '0) ? POS_W'(1) : ey_d[POS_W-1:0];
    end

    // ---------------- binning ----------------
    logic signed [POS_W+3:0] ds_x, ds_y;
    logic [NWD-1:0] n_x, n_y;
    logic [POS_W-1:0] ppx, ppy;
    logic [DSW:0] t_x, t_y;
    logic [GBM-1:0] qh_x, qh_y;

    assign ppx  = prd_reg[PEW-1 -: POS_W];
    assign ppy  = prd_reg[1 +: POS_W];
    // distance from grid origin in half-LSB, always within [E, 3E] for a kept particle
    assign ds_x = {{3{ppx[POS_W-1]}}, ppx, 1'b0} - {org_x_reg[POS_W+2], org_x_reg};
    assign ds_y = {{3{ppy[POS_W-1]}}, ppy, 1'b0} - {org_y_reg[POS_W+2], org_y_reg};
    assign n_x  = NWD'(ds_x[DSW-1:0]) * NWD'(GRID_X);
    assign n_y  = NWD'(ds_y[DSW-1:0]) * NWD'(GRID_Y);
    assign t_x  = {rem_x_reg, dlo_x_reg[QW-1]};
    assign t_y  = {rem_y_reg, dlo_y_reg[QW-1]};
    assign qh_x = q_x_reg[QW-1:FRAC_W];
    assign qh_y = q_y_reg[QW-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (cmd.lay)
        begin
            den_x_reg <= {ex, 2'b00};
            den_y_reg <= {ey, 2'b00};
            org_x_reg <= {{2{lo_x[POS_W-1]}}, lo_x, 1'b0} - (POS_W+3)'(ex);
            org_y_reg <= {{2{lo_y[POS_W-1]}}, lo_y, 1'b0} - (POS_W+3)'(ey);
        end
        if (cmd.p_chk)
        begin
            rem_x_reg <= DSW'(n_x >> GBM);
            rem_y_reg <= DSW'(n_y >> GBM);
            dlo_x_reg <= {n_x[GBM-1:0], {FRAC_W{1'b0}}};
            dlo_y_reg <= {n_y[GBM-1:0], {FRAC_W{1'b0}}};
        end
        else if (cmd.div_step)
        begin
            dlo_x_reg <= dlo_x_reg << 1;
            dlo_y_reg <= dlo_y_reg << 1;
            if (t_x >= {1'b0, den_x_reg})
            begin
                rem_x_reg <= DSW'(t_x - {1'b0, den_x_reg});
                q_x_reg   <= {q_x_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_x_reg <= t_x[DSW-1:0];
                q_x_reg   <= {q_x_reg[QW-2:0], 1'b0};
            end
            if (t_y >= {1'b0, den_y_reg})
            begin
                rem_y_reg <= DSW'(t_y - {1'b0, den_y_reg});
                q_y_reg   <= {q_y_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_y_reg <= t_y[DSW-1:0];
                q_y_reg   <= {q_y_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.bin_wr)
            base_reg <= NW'(qh_x) * NW'(GRID_Y + 1) + NW'(qh_y);
    end

    // bin/frac store
    logic          b_we;
    logic [BEW-1:0] b_wd;
    assign b_we = cmd.bin_wr || (cmd.p_chk && prd_reg[0]);
    assign b_wd = cmd.bin_wr ? {CXW'(qh_x) + CXW'(1), CYW'(qh_y) + CYW'(1),
                                q_x_reg[FRAC_W-1:0], q_y_reg[FRAC_W-1:0]} : '0;

    always_ff @(posedge clk)
    begin
        if (b_we)
            bmem[idx_reg[PW-1:0]] <= b_wd;
        if (cmd.q_bin)
            brd_reg <= bmem[particle_index];
    end

    // ---------------- weight accumulate ----------------
    logic [NW-1:0] node_addr, q_addr, rd_addr, wr_addr;
    logic [WW-1:0] fac_x, fac_y;
    logic [SW-1:0] sum;
    logic [DENS_W-1:0] wr_data;

    always_comb
    begin
        case (k_reg)
            2'd0:    node_addr = base_reg;
            2'd1:    node_addr = base_reg + NW'(1);
            2'd2:    node_addr = base_reg + NW'(GRID_Y + 1);
            default: node_addr = base_reg + NW'(GRID_Y + 2);
        endcase
        fac_x   = k_reg[1] ? WW'(q_x_reg[FRAC_W-1:0]) : ONE_Q16 - WW'(q_x_reg[FRAC_W-1:0]);
        fac_y   = k_reg[0] ? WW'(q_y_reg[FRAC_W-1:0]) : ONE_Q16 - WW'(q_y_reg[FRAC_W-1:0]);
        sum     = SW'(drd_reg) + SW'(prod_reg[2*WW-1:FRAC_W]);
        wr_data = (sum > SW'(DENS_MAX)) ? DENS_MAX : sum[DENS_W-1:0];
        q_addr  = NW'(cell_x) * NW'(GRID_Y + 1) + NW'(cell_y);
        rd_addr = cmd.q_dens ? q_addr : node_addr;
        wr_addr = cmd.clr_wr ? clr_reg : wa_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.w_rd)
        begin
            prod_reg <= (2*WW)'(fac_x) * (2*WW)'(fac_y);
            wa_reg   <= node_addr;
        end
        if (cmd.clr_wr || cmd.w_wr)
            dmem[wr_addr] <= cmd.clr_wr ? '0 : wr_data;
        if (cmd.q_dens || cmd.w_rd)
            drd_reg <= dmem[rd_addr];
    end

    // ---------------- query / output ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.q_dens)
        begin
            qsel_reg <= 1'b1;
            // before the first deposition the grid reads as zero
            off_reg  <= (cell_x > CXW'(GRID_X)) || (cell_y > CYW'(GRID_Y)) ||
                        !grid_ok_reg;
        end
        else if (cmd.q_bin)
        begin
            qsel_reg <= 1'b0;
            off_reg  <= ((CW+1)'(particle_index) >= (CW+1)'(count_reg));
        end
        if (cmd.out_load)
        begin
            density <= (qsel_reg && !off_reg) ? drd_reg : '0;
            {bin_x, bin_y, frac_x, frac_y} <= (!qsel_reg && !off_reg) ? brd_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_x_reg     <= POS_MAX;
            max_x_reg     <= POS_MIN;
            min_y_reg     <= POS_MAX;
            max_y_reg     <= POS_MIN;
            closed_reg    <= 1'b0;
            grid_ok_reg   <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= '0;
            clr_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_load)
            begin
                count_reg  <= count_next;
                min_x_reg  <= min_x_next;
                max_x_reg  <= max_x_next;
                min_y_reg  <= min_y_next;
                max_y_reg  <= max_y_next;
                closed_reg <= 1'b0;
            end
            if (cmd.lay)
            begin
                closed_reg  <= 1'b1;
                grid_ok_reg <= 1'b1;
                idx_reg     <= '0;
                clr_reg     <= '0;
            end
            if (cmd.clr_wr)
                clr_reg <= clr_reg + NW'(1);
            if (cmd.next_part)
                idx_reg <= idx_reg + CW'(1);
            if (cmd.p_chk)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + DCW'(1);
            if (cmd.bin_wr)
                k_reg <= '0;
            else if (cmd.w_wr)
                k_reg <= k_reg + 2'd1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.clr_done  = (clr_reg == NW'(NODES - 1));
        sts.empty     = (count_reg == '0);
        sts.lost      = prd_reg[0];
        sts.div_done  = (dcnt_reg == DCW'(QW - 1));
        sts.node_last = (k_reg == 2'd3);
        sts.last_part = ((idx_reg + CW'(1)) == count_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

endmodule

FILE: rtl/cloud_in_cell_density_deposit.sv
// ----------------------------------------------------------------------------
// cloud_in_cell_density_deposit
// Two-dimensional cloud-in-cell deposition: particle load, bounding box, grid
// layout, bilinear deposit into a density memory, density and binning queries.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    req_type pos_x pos_y is_lost last_particle
//                                   cell_x cell_y particle_index
//  output    out_valid / out_ready  density bin_x bin_y frac_x frac_y
//
// A load is taken in the idle state; a query waits for the output register. A load
// marked last_particle then occupies the block for the grid layout and node clear
// sweep, a read and check per particle, and per kept particle the one-bit-per-cycle
// divider over QW = clog2(max(GRID_X,GRID_Y)) + 16 quotient bits and four node
// updates on the single port of the density memory. in_ready is low throughout.
// Reset clears count, box and handshake state; memories are not cleared, and
// density reads answer 0 until the first deposition has cleared the grid.
// ----------------------------------------------------------------------------
module cloud_in_cell_density_deposit #(
    parameter int GRID_X        = cicd_pkg::GRID_X_DEF,
    parameter int GRID_Y        = cicd_pkg::GRID_Y_DEF,
    parameter int MAX_PARTICLES = cicd_pkg::MAX_PARTICLES_DEF,
    parameter int CXW           = $clog2(GRID_X + 1),
    parameter int CYW           = $clog2(GRID_Y + 1),
    parameter int PW            = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cicd_pkg::REQ_W-1:0]         req_type,
    input  logic signed [cicd_pkg::POS_W-1:0]  pos_x,
    input  logic signed [cicd_pkg::POS_W-1:0]  pos_y,
    input  logic                               is_lost,
    input  logic                               last_particle,
    input  logic [CXW-1:0]                     cell_x,
    input  logic [CYW-1:0]                     cell_y,
    input  logic [PW-1:0]                      particle_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cicd_pkg::DENS_W-1:0]        density,
    output logic [CXW-1:0]                     bin_x,
    output logic [CYW-1:0]                     bin_y,
    output logic [cicd_pkg::FRAC_W-1:0]        frac_x,
    output logic [cicd_pkg::FRAC_W-1:0]        frac_y
);
    import cicd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cicd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .last_particle (last_particle),
        .sts           (sts),
        .cmd           (cmd)
    );

    cicd_dpath #(
        .GRID_X        (GRID_X),
        .GRID_Y        (GRID_Y),
        .MAX_PARTICLES (MAX_PARTICLES),
        .CXW           (CXW),
        .CYW           (CYW),
        .PW            (PW)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .is_lost        (is_lost),
        .cell_x         (cell_x),
        .cell_y         (cell_y),
        .particle_index (particle_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .density        (density),
        .bin_x          (bin_x),
        .bin_y          (bin_y),
        .frac_x         (frac_x),
        .frac_y         (frac_y)
    );

    // node write always follows its read
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.w_wr |-> $past(cmd.w_rd))
        else $error("density write without preceding read");

    a_lay_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lay |=> cmd.clr_wr)
        else $error("grid layout not followed by clear sweep");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.clr_wr || cmd.div_step || cmd.w_wr))
        else $error("ready while deposition runs");

    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.q_dens || cmd.q_bin) |=> !in_ready)
        else $error("new transaction taken before query result loaded");

endmodule

FILE: bench/cloud_in_cell_density_deposit_test.sv
// ----------------------------------------------------------------------------
// cloud_in_cell_density_deposit_test
// Self-checking bench for the cloud-in-cell deposit block. Particle runs and
// density/binning queries are sent with random idling on both handshakes. A
// local copy of the stores, the bounding box and the density grid predicts
// every query answer. Received results are compared in order, field by field.
// ----------------------------------------------------------------------------
module cloud_in_cell_density_deposit_test;
    import cicd_pkg::*;

    localparam int GX      = GRID_X_DEF;
    localparam int GY      = GRID_Y_DEF;
    localparam int NPART   = MAX_PARTICLES_DEF;
    localparam int NODES   = (GX + 1) * (GY + 1);
    localparam longint DENS_MAX = (64'd1 << DENS_W) - 1;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;  // unknown code, ignored

    typedef struct packed {
        logic [DENS_W-1:0] density;
        logic [6:0]        bin_x;
        logic [6:0]        bin_y;
        logic [FRAC_W-1:0] frac_x;
        logic [FRAC_W-1:0] frac_y;
    } answer_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [REQ_W-1:0]  req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic              is_lost;
    logic              last_particle;
    logic [6:0]        cell_x;
    logic [6:0]        cell_y;
    logic [11:0]       particle_index;
    logic              out_valid;
    logic              out_ready;
    logic [DENS_W-1:0] density;
    logic [6:0]        bin_x;
    logic [6:0]        bin_y;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;

    cloud_in_cell_density_deposit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y),
        .is_lost(is_lost), .last_particle(last_particle),
        .cell_x(cell_x), .cell_y(cell_y), .particle_index(particle_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .density(density), .bin_x(bin_x), .bin_y(bin_y),
        .frac_x(frac_x), .frac_y(frac_y)
    );

    // predicted block state
    int      st_x [NPART];
    int      st_y [NPART];
    bit      st_lost [NPART];
    int      pr_bx [NPART];
    int      pr_by [NPART];
    int      pr_fx [NPART];
    int      pr_fy [NPART];
    longint  grid [NODES];
    int      part_cnt;
    int      box_minx, box_maxx, box_miny, box_maxy;
    bit      run_done;
    int      binned_hw;      // entries written by some deposition so far

    answer_t expected_results[$];
    int      mismatches;
    bit      quiet;
    bit      hold_req;

    always
    begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    initial
    begin
        #(20 * 3_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- predictor
    function automatic void box_clear();
        box_minx = 8388607;  box_maxx = -8388608;
        box_miny = 8388607;  box_maxy = -8388608;
    endfunction

    function automatic void lay_out(input int lo, input int hi,
                                    output longint org, output longint span);
        longint e;
        if (lo > hi)
        begin
            lo = 0; hi = 0;
        end
        e = longint'(hi) - lo;
        if (e == 0)
            e = 1;
        org  = 2 * longint'(lo) - e;
        span = 2 * e;
    endfunction

    function automatic void bin_pos(input int pos, input longint org, input longint span,
                                    input int g, output int bin, output int frac);
        longint ds, den, num, q, r;
        ds  = 2 * longint'(pos) - org;
        den = 2 * span;
        if (ds < 0)
            ds = 0;
        num = ds * g;
        q   = num / den;
        r   = num % den;
        if (q >= g)
        begin
            q = g - 1; r = den - 1;
        end
        bin  = int'(q) + 1;
        frac = int'((r << 16) / den);
    endfunction

    function automatic void add_weight(input int node, input longint a, input longint b);
        longint s;
        s = grid[node] + ((a * b) >> 16);
        grid[node] = (s > DENS_MAX) ? DENS_MAX : s;
    endfunction

    function automatic void deposit_grid();
        longint ox, oy, sx, sy;
        int bx, by, fx, fy, n;
        lay_out(box_minx, box_maxx, ox, sx);
        lay_out(box_miny, box_maxy, oy, sy);
        foreach (grid[i])
            grid[i] = 0;
        for (int i = 0; i < part_cnt; i++)
        begin
            if (st_lost[i])
            begin
                pr_bx[i] = 0; pr_by[i] = 0; pr_fx[i] = 0; pr_fy[i] = 0;
                continue;
            end
            bin_pos(st_x[i], ox, sx, GX, bx, fx);
            bin_pos(st_y[i], oy, sy, GY, by, fy);
            pr_bx[i] = bx; pr_by[i] = by; pr_fx[i] = fx; pr_fy[i] = fy;
            n = (bx - 1) * (GY + 1) + (by - 1);
            add_weight(n, 65536 - fx, 65536 - fy);
            add_weight(n + 1, 65536 - fx, fy);
            add_weight(n + GY + 1, fx, 65536 - fy);
            add_weight(n + GY + 2, fx, fy);
        end
        if (part_cnt > binned_hw)
            binned_hw = part_cnt;
    endfunction

    // state update for one accepted transaction; queues the answer if any
    function automatic void predict_transaction();
        answer_t a;
        int x, y;
        a = '0;
        case (req_type)
            REQ_LOAD:
            begin
                x = pos_x; y = pos_y;
                if (run_done)
                begin
                    part_cnt = 0;
                    box_clear();
                    run_done = 1'b0;
                end
                if (part_cnt < NPART)
                begin
                    st_x[part_cnt] = x; st_y[part_cnt] = y; st_lost[part_cnt] = is_lost;
                    if (!is_lost)
                    begin
                        if (x < box_minx) box_minx = x;
                        if (x > box_maxx) box_maxx = x;
                        if (y < box_miny) box_miny = y;
                        if (y > box_maxy) box_maxy = y;
                    end
                    part_cnt++;
                end
                if (last_particle)
                begin
                    deposit_grid();
                    run_done = 1'b1;
                end
            end
            REQ_DENS:
            begin
                if (cell_x <= GX && cell_y <= GY)
                    a.density = grid[cell_x * (GY + 1) + cell_y];
                expected_results.push_back(a);
            end
            REQ_BIN:
            begin
                if (particle_index < part_cnt)
                begin
                    a.bin_x  = pr_bx[particle_index];
                    a.bin_y  = pr_by[particle_index];
                    a.frac_x = pr_fx[particle_index];
                    a.frac_y = pr_fy[particle_index];
                end
                expected_results.push_back(a);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver
    task automatic send_item(input logic [REQ_W-1:0] rq, input logic [23:0] x,
                             input logic [23:0] y, input bit lost, input bit last,
                             input logic [6:0] cx, input logic [6:0] cy,
                             input logic [11:0] pidx);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 13);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1; req_type = rq; pos_x = x; pos_y = y;
        is_lost = lost; last_particle = last;
        cell_x = cx; cell_y = cy; particle_index = pidx;
        do
            @(posedge clk);
        while (!in_ready);
        predict_transaction();
    endtask

    task automatic load_particle(input logic [23:0] x, input logic [23:0] y,
                                 input bit lost, input bit last);
        send_item(REQ_LOAD, x, y, lost, last, $urandom, $urandom, $urandom);
    endtask

    task automatic read_density(input logic [6:0] cx, input logic [6:0] cy);
        send_item(REQ_DENS, $urandom, $urandom, $urandom, $urandom, cx, cy, $urandom);
    endtask

    task automatic read_binning(input logic [11:0] p);
        // keep away from entries that no deposition has written
        if (p < part_cnt && p >= binned_hw)
        begin
            if (binned_hw > 0)
                p = p % binned_hw;
            else if (part_cnt < NPART)
                p = $urandom_range(part_cnt, NPART - 1);
        end
        send_item(REQ_BIN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, p);
    endtask

    task automatic read_random();
        int k, dx, dy;
        case ($urandom_range(0, 5))
            0: send_item(REQ_NONE, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
            1, 2: read_binning($urandom_range(0, part_cnt + 3));
            3: read_density($urandom, $urandom);
            default:
            begin
                // aim at a node next to a binned particle
                k = (binned_hw > 0) ? $urandom_range(0, binned_hw - 1) : 0;
                dx = $urandom_range(0, 1); dy = $urandom_range(0, 1);
                read_density(pr_bx[k] + dx - 1 + (pr_bx[k] == 0),
                             pr_by[k] + dy - 1 + (pr_by[k] == 0));
            end
        endcase
    endtask

    // random run of n loads; spread masks the offset from a random base
    task automatic random_run(input int n, input int interleave);
        logic [23:0] bx, by, spread;
        bx = $urandom; by = $urandom;
        case ($urandom_range(0, 3))
            0: spread = 24'h00000f;
            1: spread = 24'h000fff;
            2: spread = 24'h0fffff;
            default: spread = 24'hffffff;
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (interleave && $urandom_range(0, 7) == 0)
                read_random();
            load_particle(bx + ($urandom & spread), by + ($urandom & spread),
                          $urandom_range(0, 5) == 0, i == n - 1);
        end
    endtask

    // ---------------------------------------------------------------- receiver
    initial
    begin
        int left;
        left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
                left = 0;
            end
            else if (quiet)
                out_ready = 1'b1;
            else if (left == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    out_ready = 1'b0; left = $urandom_range(1, 13);
                end
                else
                begin
                    out_ready = 1'b1; left = $urandom_range(1, 24);
                end
            end
            else
                left--;
        end
    end

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                mismatches++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (density !== e.density)
                begin
                    $error("density: expected %0d, got %0d", e.density, density);
                    mismatches++;
                end
                if (bin_x !== e.bin_x)
                begin
                    $error("bin_x: expected %0d, got %0d", e.bin_x, bin_x);
                    mismatches++;
                end
                if (bin_y !== e.bin_y)
                begin
                    $error("bin_y: expected %0d, got %0d", e.bin_y, bin_y);
                    mismatches++;
                end
                if (frac_x !== e.frac_x)
                begin
                    $error("frac_x: expected %0d, got %0d", e.frac_x, frac_x);
                    mismatches++;
                end
                if (frac_y !== e.frac_y)
                begin
                    $error("frac_y: expected %0d, got %0d", e.frac_y, frac_y);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        // fresh block: nothing loaded, nothing deposited
        read_binning(0);
        read_binning(12'hfff);
        read_density(7'h7f, 7'h7f);
        read_density(5, 9);
        send_item(REQ_NONE, 24'hffffff, 24'hffffff, 1, 1, 7'h7f, 7'h7f, 12'hfff);
        // full-range extremes, one lost particle
        load_particle(24'h800000, 24'h7fffff, 0, 0);
        load_particle(24'h000000, 24'h000000, 1, 0);
        load_particle(24'h7fffff, 24'h800000, 0, 1);
        read_binning(0);
        read_binning(1);
        read_binning(2);
        read_binning(3);
        read_density(0, 0);
        read_density(GX, GY);
        read_density(GX + 1, 0);
        read_density(0, GY + 1);
        // zero extent: one kept particle
        load_particle(24'h123456, 24'hfedcba, 0, 1);
        read_binning(0);
        read_density(16, 16);
        // open run reads back the last deposition
        load_particle(24'h000010, 24'h000020, 1, 0);
        read_binning(0);
        read_binning(1);
        // no kept particle at all
        load_particle(24'h000030, 24'h000040, 1, 1);
        read_binning(1);
        read_density(32, 32);
    endtask

    task automatic test_random_runs();
        int items;
        items = 0;
        while (items < 1000)
        begin
            random_run($urandom_range(1, 24), 1);
            for (int q = $urandom_range(4, 14); q > 0; q--)
                read_random();
            items += 30;
        end
    endtask

    task automatic test_output_stall();
        random_run(6, 0);
        hold_req = 1'b1;
        for (int q = 0; q < 30; q++)
            read_random();
    endtask

    task automatic test_store_full();
        // a few loads past the store depth; the final mark still deposits
        for (int i = 0; i < NPART + 4; i++)
            load_particle($urandom, $urandom, $urandom_range(0, 1), i == NPART + 3);
        read_binning(NPART - 1);
        read_binning(0);
        for (int q = 0; q < 20; q++)
            read_random();
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        random_run(10, 1);
        for (int q = 0; q < 40; q++)
            read_random();
    endtask

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0; in_valid = 1'b0; req_type = REQ_LOAD;
        pos_x = '0; pos_y = '0; is_lost = 1'b0; last_particle = 1'b0;
        cell_x = '0; cell_y = '0; particle_index = '0;
        mismatches = 0; quiet = 1'b0; hold_req = 1'b0;
        part_cnt = 0; run_done = 1'b0; binned_hw = 0;
        box_clear();
        foreach (grid[i])
            grid[i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_runs();
        test_output_stall();
        test_store_full();
        test_back_to_back();

        @(negedge clk);
        in_valid = 1'b0;
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
